>>> src/mrbc_pkg.sv
// ----------------------------------------------------------------------------
// mrbc_pkg
// shared types and codes of the memory range bounds checker
// ----------------------------------------------------------------------------
`default_nettype none

package mrbc_pkg;

	typedef enum logic [2:0] {
		OP_STACK  = 3'd0,
		OP_RETURN = 3'd1,
		OP_CALL   = 3'd2,
		OP_HEAP   = 3'd3,
		OP_GLOBAL = 3'd4,
		OP_LOAD   = 3'd5,
		OP_STORE  = 3'd6,
		OP_FREE   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_READ      = 3'd1,
		ERR_WRITE     = 3'd2,
		ERR_FREE      = 3'd3,
		ERR_FULL      = 3'd4,
		ERR_DEPTH     = 3'd5
	} err_t;

	typedef enum logic [1:0] {
		KIND_STACK  = 2'd0,
		KIND_GLOBAL = 2'd1,
		KIND_HEAP   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_STOP_ALL  = 2'd0,
		MODE_STOP_READ = 2'd1,
		MODE_IGNORE    = 2'd2,
		MODE_BYPASS    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} state_t;

	localparam int ADDR_W = 48;
	localparam int LEN_W  = 32;

endpackage

`default_nettype wire

>>> src/mrbc_mem.sv
// ----------------------------------------------------------------------------
// mrbc_mem
// simple dual port range table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mrbc_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 90
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/memory_range_bounds_checker.sv
// ----------------------------------------------------------------------------
// memory_range_bounds_checker
// range table with stack, global and heap entries; checks loads, stores, frees
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  operation, address, length
// out       output     out_valid / out_stall ok, fatal, error_kind
// cfg       input      cfg_valid / cfg_ready cfg_data (analysis mode)
//
// inserts, returns, loads, stores and non-null frees walk the table one entry
// a cycle through the single memory read port
// calls and frees of null skip the walk
// reset clears valid bits, depth and mode at once; no clearing pass
// a result waits in the output register while the next item is accepted
// ----------------------------------------------------------------------------
`default_nettype none

module memory_range_bounds_checker
	import mrbc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64,
	parameter int MAX_DEPTH     = 255
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        operation,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic [LEN_W-1:0]  length,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   ok,
	output logic                   fatal,
	output logic [2:0]             error_kind,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_data
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int EW = ADDR_W + LEN_W + 2 + DW;

	state_t            state_q, state_d;
	op_t               op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [1:0]        mode_q;
	logic [DW-1:0]     depth_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IW-1:0]     idx_q;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;

	logic              match_q, free_q, best_q, hit_q;
	logic [IW-1:0]     match_idx_q, free_idx_q;
	logic [ADDR_W-1:0] best_base_q;
	logic [LEN_W-1:0]  best_size_q;

	logic              out_valid_q, ok_q, fatal_q;
	err_t              err_q;

	logic [EW-1:0]     rdata, wdata;
	logic [ADDR_W-1:0] e_base;
	logic [LEN_W-1:0]  e_size;
	kind_t             e_kind;
	logic [DW-1:0]     e_level;
	logic              e_valid;

	logic              accept, commit, scan_op, we;
	logic [IW-1:0]     slot;
	logic              res_ok, res_fatal;
	err_t              res_err;
	logic [ADDR_W:0]   acc_end, rng_end;

	assign e_base  = rdata[EW-1 -: ADDR_W];
	assign e_size  = rdata[EW-ADDR_W-1 -: LEN_W];
	assign e_kind  = kind_t'(rdata[DW+1 -: 2]);
	assign e_level = rdata[DW-1:0];
	assign e_valid = vld_s1 && valid_q[idx_s1];

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign scan_op   = !(op_t'(operation) == OP_CALL ||
		(op_t'(operation) == OP_FREE && address == '0));

	assign commit = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign slot   = match_q ? match_idx_q : free_idx_q;
	assign we     = commit && (op_q == OP_STACK || op_q == OP_HEAP || op_q == OP_GLOBAL) &&
		(match_q || free_q);

	always_comb begin
		unique case (op_q)
			OP_HEAP:   wdata = {addr_q, len_q, KIND_HEAP, depth_q};
			OP_GLOBAL: wdata = {addr_q, len_q, KIND_GLOBAL, depth_q};
			default:   wdata = {addr_q, len_q, KIND_STACK, depth_q};
		endcase
	end

	mrbc_mem #(
		.DEPTH (TABLE_ENTRIES),
		.WIDTH (EW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (slot),
		.wdata (wdata),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign acc_end = {1'b0, addr_q} + {{(ADDR_W-LEN_W+1){1'b0}}, len_q};
	assign rng_end = {1'b0, best_base_q} + {{(ADDR_W-LEN_W+1){1'b0}}, best_size_q};

	always_comb begin
		res_ok    = 1'b1;
		res_fatal = 1'b0;
		res_err   = ERR_NONE;
		unique case (op_q)
			OP_STACK, OP_HEAP, OP_GLOBAL: begin
				if (!(match_q || free_q)) begin
					res_ok  = 1'b0;
					res_err = ERR_FULL;
				end
			end
			OP_CALL: begin
				if (depth_q == DW'(MAX_DEPTH)) begin
					res_ok  = 1'b0;
					res_err = ERR_DEPTH;
				end
			end
			OP_LOAD, OP_STORE: begin
				if (!best_q || acc_end > rng_end) begin
					res_ok    = 1'b0;
					res_err   = (op_q == OP_LOAD) ? ERR_READ : ERR_WRITE;
					res_fatal = (op_q == OP_LOAD) ?
						(mode_q == MODE_STOP_ALL || mode_q == MODE_STOP_READ) :
						(mode_q == MODE_STOP_ALL);
				end
			end
			OP_FREE: begin
				if (addr_q != '0 && !hit_q) begin
					res_ok    = 1'b0;
					res_err   = ERR_FREE;
					res_fatal = (mode_q == MODE_STOP_ALL);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = scan_op ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (idx_q == IW'(TABLE_ENTRIES - 1)) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item capture, match, free and best entry tracking, and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(operation);
			addr_q <= address;
			len_q  <= length;
		end
		if (vld_s1) begin
			idx_s1 <= idx_q;
		end else begin
			idx_s1 <= idx_q;
		end
		if (e_valid && (e_base == addr_q)) begin
			match_idx_q <= idx_s1;
		end
		if (vld_s1 && !valid_q[idx_s1] && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (e_valid && e_base <= addr_q && (!best_q || e_base > best_base_q)) begin
			best_base_q <= e_base;
			best_size_q <= e_size;
		end
		if (commit) begin
			ok_q    <= res_ok;
			fatal_q <= res_fatal;
			err_q   <= res_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			best_q      <= 1'b0;
			hit_q       <= 1'b0;
			valid_q     <= '0;
			depth_q     <= '0;
			mode_q      <= MODE_STOP_ALL;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			if (accept) begin
				idx_q   <= '0;
				match_q <= 1'b0;
				free_q  <= 1'b0;
				best_q  <= 1'b0;
				hit_q   <= 1'b0;
			end else if (state_q == ST_SCAN && idx_q != IW'(TABLE_ENTRIES - 1)) begin
				idx_q <= idx_q + IW'(1);
			end
			if (e_valid && e_base == addr_q) begin
				match_q <= 1'b1;
			end
			if (vld_s1 && !valid_q[idx_s1]) begin
				free_q <= 1'b1;
			end
			if (e_valid && e_base <= addr_q && (!best_q || e_base > best_base_q)) begin
				best_q <= 1'b1;
			end
			// entry clears during the walk
			if (e_valid && op_q == OP_RETURN && e_kind == KIND_STACK && e_level == depth_q) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (e_valid && op_q == OP_FREE && e_base == addr_q && e_kind == KIND_HEAP) begin
				valid_q[idx_s1] <= 1'b0;
				hit_q           <= 1'b1;
			end
			if (we) begin
				valid_q[slot] <= 1'b1;
			end
			if (commit && op_q == OP_CALL && depth_q != DW'(MAX_DEPTH)) begin
				depth_q <= depth_q + DW'(1);
			end
			if (commit && op_q == OP_RETURN && depth_q != '0) begin
				depth_q <= depth_q - DW'(1);
			end
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign fatal      = fatal_q;
	assign error_kind = err_q;

endmodule

`default_nettype wire

>>> src/mrbc_checker.sv
// ----------------------------------------------------------------------------
// mrbc_checker
// port level checks of the memory range bounds checker
// ----------------------------------------------------------------------------
`default_nettype none

module mrbc_checker
	import mrbc_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       ok,
	input wire logic       fatal,
	input wire logic [2:0] error_kind
);

	// a stalled item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok |-> error_kind == ERR_NONE && !fatal)
		else $error("passing item carries an error");

	a_fail_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> error_kind != ERR_NONE)
		else $error("failing item has no error code");

	a_fatal_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fatal |-> error_kind == ERR_READ || error_kind == ERR_WRITE ||
			error_kind == ERR_FREE)
		else $error("fatal on a non-access error");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while busy");

endmodule

bind memory_range_bounds_checker mrbc_checker u_mrbc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.ok         (ok),
	.fatal      (fatal),
	.error_kind (error_kind)
);

`default_nettype wire
